// ===== hdl/sha256_pkg.sv =====
// sha256_pkg: shared types, constants and rotate helper for the byte-stream hasher
// no dependencies

package sha256_pkg;

	localparam int unsigned NumRoundsDefault = 64;
	localparam int unsigned CountWidth = 61;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
		logic       no_data;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic put_byte;     // merge in_byte at current position, count it
		logic put_pad;      // merge 0x80 at current position
		logic put_len;      // write bit length into words 14 and 15
		logic comp_start;   // load working vars from chain value
		logic comp_round;   // one round plus schedule shift
		logic comp_final;   // add working vars to chain value, clear block
		logic clear_all;    // back to reset state
		logic [6:0] round;  // round number for constant lookup
	} dp_cmd_t;

	typedef struct packed {
		logic       block_full; // position is 63 before put
		logic       pad_two;    // position at or above 56
	} dp_stat_t;

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ===== hdl/sha256_byte_stream_hasher.sv =====
// sha256_byte_stream_hasher: top level, joins sequencer and datapath
// depends on sha256_pkg, sha256_ctrl, sha256_dp
//
// channel | direction | payload    | handshake
// in      | input     | in_item_t  | in_valid / in_stall
// out     | output    | out_item_t | out_valid / out_stall
//
// a byte that does not fill a block is merged into the buffer; the 64th byte
// of a block starts a compression in the shared round unit
// a last item adds padding: one or two compressions, then eight digest words
// reset restores the initial hash; no clearing pass
// in_stall is high whenever the sequencer is busy; out_stall holds the word

module sha256_byte_stream_hasher
	import sha256_pkg::*;
#(
	parameter int unsigned NUM_ROUNDS = NumRoundsDefault
)(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	dp_cmd_t    cmd;
	dp_stat_t   stat;
	logic [2:0] word_idx;
	logic [31:0] rd_word;

	sha256_ctrl #(.NUM_ROUNDS(NUM_ROUNDS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_item(in_data),
		.in_stall(in_stall), .out_stall(out_stall), .out_valid(out_valid),
		.word_idx(word_idx), .cmd(cmd), .stat(stat)
	);

	sha256_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_byte(in_data.data_byte),
		.rd_idx(word_idx), .rd_word(rd_word), .stat(stat)
	);

	assign out_data.digest_word = rd_word;
	assign out_data.word_index = word_idx;
	assign out_data.last_word = (word_idx == 3'd7);

endmodule

// ===== hdl/sha256_dp.sv =====
// sha256_dp: block buffer, rolling message schedule, round unit and chain value
// depends on sha256_pkg

module sha256_dp
	import sha256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  logic [7:0]  in_byte,
	input  logic [2:0]  rd_idx,
	output logic [31:0] rd_word,
	output dp_stat_t    stat
);

	logic [31:0] win_q [16];
	logic [31:0] var_q [8];
	logic [31:0] hash_q [8];
	logic [CountWidth-1:0] count_q;

	logic [5:0]  pos;
	logic [31:0] w_new, t1, t2, s0, s1, e, a;
	logic [7:0]  put_val;
	logic [63:0] bit_len;

	assign pos = count_q[5:0];
	assign stat.block_full = (pos == 6'd63);
	assign stat.pad_two = (pos >= 6'd56);
	assign rd_word = hash_q[rd_idx];
	assign put_val = cmd.put_pad ? 8'h80 : in_byte;
	assign bit_len = {count_q, 3'b000};

	// schedule expansion and round function
	always_comb begin
		s0 = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
		s1 = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
		w_new = s1 + win_q[9] + s0 + win_q[0];
		e = var_q[4];
		a = var_q[0];
		t1 = var_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
			+ ((e & var_q[5]) ^ (~e & var_q[6])) + RoundK[cmd.round[5:0]] + win_q[0];
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
			+ ((a & var_q[1]) ^ (a & var_q[2]) ^ (var_q[1] & var_q[2]));
	end

	// block window and schedule shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) win_q[i] <= '0;
		end else if (cmd.clear_all || cmd.comp_final) begin
			for (int i = 0; i < 16; i++) win_q[i] <= '0;
		end else if (cmd.comp_round) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
			win_q[15] <= w_new;
		end else begin
			if (cmd.put_byte || cmd.put_pad) begin
				unique case (pos[1:0])
					2'd0: win_q[pos[5:2]][31:24] <= win_q[pos[5:2]][31:24] | put_val;
					2'd1: win_q[pos[5:2]][23:16] <= win_q[pos[5:2]][23:16] | put_val;
					2'd2: win_q[pos[5:2]][15:8]  <= win_q[pos[5:2]][15:8]  | put_val;
					default: win_q[pos[5:2]][7:0] <= win_q[pos[5:2]][7:0] | put_val;
				endcase
			end
			if (cmd.put_len) begin
				win_q[14] <= bit_len[63:32];
				win_q[15] <= bit_len[31:0];
			end
		end
	end

	// byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (cmd.clear_all) count_q <= '0;
		else if (cmd.put_byte) count_q <= count_q + 1'b1;
	end

	// working variables and chain value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				var_q[i] <= '0;
				hash_q[i] <= InitHash[i];
			end
		end else if (cmd.clear_all) begin
			for (int i = 0; i < 8; i++) begin
				var_q[i] <= '0;
				hash_q[i] <= InitHash[i];
			end
		end else if (cmd.comp_start) begin
			for (int i = 0; i < 8; i++) var_q[i] <= hash_q[i];
		end else if (cmd.comp_round) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end else if (cmd.comp_final) begin
			for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + var_q[i];
		end
	end

endmodule

// ===== hdl/sha256_ctrl.sv =====
// sha256_ctrl: sequencer for byte intake, padding, compression and digest output
// depends on sha256_pkg

module sha256_ctrl
	import sha256_pkg::*;
#(
	parameter int unsigned NUM_ROUNDS = NumRoundsDefault
)(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  in_item_t  in_item,
	output logic      in_stall,
	input  logic      out_stall,
	output logic      out_valid,
	output logic [2:0] word_idx,
	output dp_cmd_t   cmd,
	input  dp_stat_t  stat
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_START = 8'b0000_0010,
		ST_ROUND = 8'b0000_0100,
		ST_FINAL = 8'b0000_1000,
		ST_PAD   = 8'b0001_0000,
		ST_LEN   = 8'b0010_0000,
		ST_OUT   = 8'b0100_0000,
		ST_CLEAR = 8'b1000_0000
	} state_t;

	// after a compression (one-hot): idle or digest output, pad, length
	typedef enum logic [2:0] {
		NX_IDLE = 3'b001,
		NX_PAD  = 3'b010,
		NX_LEN  = 3'b100
	} next_t;

	state_t state_q;
	next_t  next_q;
	logic [6:0] round_q;
	logic [2:0] word_q;
	logic accept;
	logic final_flag_q;

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign out_valid = (state_q == ST_OUT);
	assign word_idx = word_q;

	// command decode
	always_comb begin
		cmd = '0;
		cmd.round = round_q;
		unique case (state_q)
			ST_IDLE:  cmd.put_byte = accept && !in_item.no_data;
			ST_START: cmd.comp_start = 1'b1;
			ST_ROUND: cmd.comp_round = 1'b1;
			ST_FINAL: cmd.comp_final = 1'b1;
			ST_PAD:   cmd.put_pad = 1'b1;
			ST_LEN:   cmd.put_len = 1'b1;
			ST_CLEAR: cmd.clear_all = 1'b1;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			next_q <= NX_IDLE;
			round_q <= '0;
			word_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!in_item.no_data && stat.block_full) begin
							state_q <= ST_START;
							next_q <= in_item.is_last ? NX_PAD : NX_IDLE;
						end else if (in_item.is_last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_START: begin
					round_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (round_q == 7'(NUM_ROUNDS - 1)) state_q <= ST_FINAL;
					else round_q <= round_q + 1'b1;
				end
				ST_FINAL: begin
					// final compression of a message goes to digest output
					unique case (next_q)
						NX_PAD:  state_q <= ST_PAD;
						NX_LEN:  state_q <= ST_LEN;
						default: begin
							if (final_flag_q) begin
								state_q <= ST_OUT;
								word_q <= '0;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					endcase
				end
				ST_PAD: begin
					// second block needed when no room for the length
					next_q <= stat.pad_two ? NX_LEN : NX_IDLE;
					if (stat.pad_two) state_q <= ST_START;
					else state_q <= ST_LEN;
				end
				ST_LEN: begin
					state_q <= ST_START;
					next_q <= NX_IDLE;
					word_q <= '0;
				end
				ST_OUT: begin
					if (!out_stall) begin
						if (word_q == 3'd7) state_q <= ST_CLEAR;
						else word_q <= word_q + 1'b1;
					end
				end
				ST_CLEAR: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// marks that the running compression closes the message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) final_flag_q <= 1'b0;
		else if (state_q == ST_LEN) final_flag_q <= 1'b1;
		else if (state_q == ST_CLEAR) final_flag_q <= 1'b0;
	end

endmodule
